// File: hdl/cdte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cdte_pkg;

   // calendar constants
   localparam logic [11:0] EPOCH_YEAR         = 12'd1970;
   localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
   localparam logic [8:0]  LEAPS_BEFORE_EPOCH = 9'd477;
   localparam logic [16:0] SECS_PER_DAY       = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR      = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN       = 6'd60;
   localparam logic [3:0]  MONTH_FIRST        = 4'd1;
   localparam logic [3:0]  MONTH_LAST         = 4'd12;
   localparam logic [3:0]  MONTH_FEB          = 4'd2;

   // floor(n / 100) = (n * RECIP_100) >> RECIP_SHIFT, exact for 12-bit n
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam logic [6:0]  CENTURY     = 7'd100;

   // days before the first of each month, non-leap year
   localparam logic [8:0] DAYS_BEFORE_MONTH [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // day count stage to seconds stage
   typedef struct packed {
      logic        valid;
      logic [31:0] days;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } days_stage_type;

endpackage
`default_nettype wire

// File: hdl/calendar_date_to_epoch_seconds_top.sv
`timescale 1ns / 1ps
`default_nettype none
// calendar date to epoch seconds
// input: raise start with a date and time of day on the req_ ports; the
//    transaction is taken at a rising edge with start high and busy low.
//    busy stays low, so a new date may enter in every cycle.
// output: rsp_valid is high for exactly one cycle with rsp_epoch_seconds,
//    the seconds since 1970-01-01 00:00 minus the zone offset, modulo 2^32.
//    the receiver cannot hold results off and none is needed.
// pipeline: throughput one transaction per cycle, through the five register
//    stages (clamp and reciprocal products, leap count, day sum,
//    day-to-seconds multiply, final sum).
// config: csr_wr_en with csr_wr_data writes the signed zone offset in
//    minutes; write it only while no transaction is in flight.
// reset: synchronous, clears the pipeline valid bits and sets the zone
//    offset to zero; nothing in flight survives reset.
module calendar_date_to_epoch_seconds_top
   import cdte_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [11:0] req_year_full,
   input  wire logic [3:0]  req_month_num,
   input  wire logic [4:0]  req_day_of_month,
   input  wire logic [4:0]  req_hour_of_day,
   input  wire logic [5:0]  req_minute_of_hour,
   input  wire logic [5:0]  req_second_of_minute,
   output logic             rsp_valid,
   output logic [31:0]      rsp_epoch_seconds,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   // zone offset register
   logic signed [15:0] zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= 16'sd0;
      end else if (csr_wr_en) begin
         zone_ff <= $signed(csr_wr_data);
      end
   end

   // the pipeline never stalls
   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // date to day count
   days_stage_type days_link;

   cdte_days u_days (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (accept),
      .year_full        (req_year_full),
      .month_num        (req_month_num),
      .day_of_month     (req_day_of_month),
      .hour_of_day      (req_hour_of_day),
      .minute_of_hour   (req_minute_of_hour),
      .second_of_minute (req_second_of_minute),
      .days_out         (days_link)
   );

   // day count to seconds
   cdte_secs u_secs (
      .clock       (clock),
      .reset       (reset),
      .days_in     (days_link),
      .zone_offset (zone_ff),
      .out_valid   (rsp_valid),
      .out_seconds (rsp_epoch_seconds)
   );

endmodule
`default_nettype wire

// File: hdl/cdte_days.sv
`timescale 1ns / 1ps
`default_nettype none
module cdte_days
   import cdte_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire logic [11:0]    year_full,
   input  wire logic [3:0]     month_num,
   input  wire logic [4:0]     day_of_month,
   input  wire logic [4:0]     hour_of_day,
   input  wire logic [5:0]     minute_of_hour,
   input  wire logic [5:0]     second_of_minute,
   output days_stage_type      days_out
);

   // stage 1: month clamp, table lookup, reciprocal products
   logic [3:0]  month_cl;
   logic [3:0]  month_idx;
   logic [8:0]  dbm1_in;
   logic        late1_in;
   logic [24:0] prodn1_in;
   logic [24:0] prody1_in;

   logic        valid1_ff;
   logic [11:0] year1_ff;
   logic [8:0]  dbm1_ff;
   logic        late1_ff;
   logic [4:0]  day1_ff;
   logic [4:0]  hour1_ff;
   logic [5:0]  minute1_ff;
   logic [5:0]  second1_ff;
   logic [24:0] prodn1_ff;
   logic [24:0] prody1_ff;

   always_comb begin
      if (month_num < MONTH_FIRST) begin
         month_cl = MONTH_FIRST;
      end else if (month_num > MONTH_LAST) begin
         month_cl = MONTH_LAST;
      end else begin
         month_cl = month_num;
      end
      month_idx = month_cl - MONTH_FIRST;
      dbm1_in   = DAYS_BEFORE_MONTH[month_idx];
      late1_in  = (month_cl > MONTH_FEB);
      prodn1_in = 25'(year_full - 12'd1) * 25'(RECIP_100);
      prody1_in = 25'(year_full) * 25'(RECIP_100);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
      year1_ff   <= year_full;
      dbm1_ff    <= dbm1_in;
      late1_ff   <= late1_in;
      day1_ff    <= day_of_month;
      hour1_ff   <= hour_of_day;
      minute1_ff <= minute_of_hour;
      second1_ff <= second_of_minute;
      prodn1_ff  <= prodn1_in;
      prody1_ff  <= prody1_in;
   end

   // stage 2: leap count, leap year test, year term
   logic [11:0] year_m1;
   logic [5:0]  q_n;
   logic [5:0]  q_y;
   logic [11:0] rem_y;
   logic [10:0] leaps_n;
   logic        leap_year;
   logic [10:0] leaps2_in;
   logic [31:0] yterm2_in;
   logic        leapadj2_in;

   logic        valid2_ff;
   logic [31:0] yterm2_ff;
   logic [10:0] leaps2_ff;
   logic [8:0]  dbm2_ff;
   logic        leapadj2_ff;
   logic [4:0]  day2_ff;
   logic [4:0]  hour2_ff;
   logic [5:0]  minute2_ff;
   logic [5:0]  second2_ff;

   always_comb begin
      year_m1   = year1_ff - 12'd1;
      q_n       = prodn1_ff[RECIP_SHIFT +: 6];
      q_y       = prody1_ff[RECIP_SHIFT +: 6];
      rem_y     = year1_ff - 12'(12'(q_y) * 12'(CENTURY));
      leaps_n   = 11'(year_m1 >> 2) - 11'(q_n) + 11'(q_n >> 2);
      leap_year = ((year1_ff[1:0] == 2'd0) && (rem_y != 12'd0))
                  || ((rem_y == 12'd0) && (q_y[1:0] == 2'd0));
      if (year1_ff > EPOCH_YEAR) begin
         leaps2_in = leaps_n - 11'(LEAPS_BEFORE_EPOCH);
      end else begin
         leaps2_in = 11'd0;
      end
      yterm2_in   = (32'(year1_ff) - 32'(EPOCH_YEAR)) * 32'(DAYS_PER_YEAR);
      leapadj2_in = late1_ff && leap_year;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
      yterm2_ff   <= yterm2_in;
      leaps2_ff   <= leaps2_in;
      dbm2_ff     <= dbm1_ff;
      leapadj2_ff <= leapadj2_in;
      day2_ff     <= day1_ff;
      hour2_ff    <= hour1_ff;
      minute2_ff  <= minute1_ff;
      second2_ff  <= second1_ff;
   end

   // stage 3: total day count, wraps modulo 2^32
   logic [31:0]    days3_in;
   days_stage_type days3_ff;

   always_comb begin
      days3_in = yterm2_ff + 32'(leaps2_ff) + 32'(dbm2_ff) + 32'(leapadj2_ff)
                 + 32'(day2_ff) - 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         days3_ff.valid <= 1'b0;
      end else begin
         days3_ff.valid <= valid2_ff;
      end
      days3_ff.days   <= days3_in;
      days3_ff.hour   <= hour2_ff;
      days3_ff.minute <= minute2_ff;
      days3_ff.second <= second2_ff;
   end

   assign days_out = days3_ff;

endmodule
`default_nettype wire

// File: hdl/cdte_secs.sv
`timescale 1ns / 1ps
`default_nettype none
module cdte_secs
   import cdte_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire days_stage_type      days_in,
   input  wire logic signed [15:0]  zone_offset,
   output logic                     out_valid,
   output logic [31:0]              out_seconds
);

   // stage 4: day seconds, time of day, zone seconds
   logic [31:0] daysec4_in;
   logic [16:0] tod4_in;
   logic [31:0] zone4_in;

   logic        valid4_ff;
   logic [31:0] daysec4_ff;
   logic [16:0] tod4_ff;
   logic [31:0] zone4_ff;

   always_comb begin
      daysec4_in = days_in.days * 32'(SECS_PER_DAY);
      tod4_in    = 17'(days_in.hour) * 17'(SECS_PER_HOUR)
                   + 17'(days_in.minute) * 17'(SECS_PER_MIN)
                   + 17'(days_in.second);
      zone4_in   = 32'(32'(zone_offset) * 32'sd60);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else begin
         valid4_ff <= days_in.valid;
      end
      daysec4_ff <= daysec4_in;
      tod4_ff    <= tod4_in;
      zone4_ff   <= zone4_in;
   end

   // stage 5: final sum into the output register
   logic [31:0] result_in;
   logic        valid5_ff;
   logic [31:0] result_ff;

   always_comb begin
      result_in = daysec4_ff + 32'(tod4_ff) - zone4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid5_ff <= 1'b0;
      end else begin
         valid5_ff <= valid4_ff;
      end
      result_ff <= result_in;
   end

   assign out_valid   = valid5_ff;
   assign out_seconds = result_ff;

endmodule
`default_nettype wire
